/* rtl/core/dpc_pkg.sv */
// Shared types, widths and constants of the DBSCAN point clustering block.
`default_nettype none
package dpc_pkg;

    localparam int POINTS_DEF  = 64;
    localparam int COORD_W_DEF = 16;

    localparam int CNT_W      = 7;
    localparam int KEPT_W     = 6;
    localparam int LABEL_W    = 7;
    localparam int RADIUS_W   = 15;
    localparam int MINN_W     = 7;
    localparam int GATE_W     = 16;
    localparam int R2_W       = 2 * RADIUS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LABEL_W-1:0]    LABEL_NOISE  = {LABEL_W{1'b1}};
    localparam logic [RADIUS_W-1:0]   RADIUS_RST   = 15'd300;
    localparam logic [MINN_W-1:0]     MINN_RST     = 7'd5;
    localparam logic [GATE_W-1:0]     GATE_RST     = 16'd2700;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             overflow;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_OUTER,
        B_PREAD,
        B_PLATCH,
        B_SCAN,
        B_DECIDE,
        B_PUSH,
        B_LABEL,
        B_QHEAD,
        B_QWAIT,
        B_ERD,
        B_EOUT,
        B_EWAIT
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/core/dbscan_point_clustering.sv */
// Top level of the DBSCAN point clustering block: configuration, front end, job queue, engine.
//
//  Channel  Direction  Handshake          Moves
//  s_       in         s_valid/s_ready    one 3-D point request, end_of_frame on the last
//  m_       out        m_valid/m_ready    one cluster label request per kept point
//  cfg_     in         cfg_we             register write, index and data, no back-pressure
//
// Accepted points that pass the height gate are written to the point store while it has
// room. After the last point the engine tests each visited point against every stored
// point through a pipelined squared-distance test, reading the point store through its
// single read port, and a core point then pushes its unqueued neighbours onto the frontier
// queue. Labels are then emitted one at a time, each held until m_ready takes it.
// Reset is synchronous and active low; configuration returns to radius 300, five
// neighbours and a 2700 mm height gate. Points for the next frame are accepted while the
// previous frame's labels are still being emitted, but not while it is being clustered.
`default_nettype none
module dbscan_point_clustering #(
    parameter int POINTS      = dpc_pkg::POINTS_DEF,
    parameter int COORD_WIDTH = dpc_pkg::COORD_W_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]  s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]  s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]  s_pos_z,
    input  wire                                 s_end_of_frame,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [dpc_pkg::KEPT_W-1:0]          m_kept_index,
    output logic signed [dpc_pkg::LABEL_W-1:0]  m_cluster_label,
    output logic                                m_last_label,
    output logic                                m_overflow,
    input  wire                                 cfg_we,
    input  wire [dpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [dpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    localparam int IW = $clog2(POINTS);
    localparam int PW = 3 * COORD_WIDTH;

    // Configuration registers. The squared radius is registered from the radius so the
    // distance compare never sees a multiplier in its path.
    logic [dpc_pkg::RADIUS_W-1:0] radius_reg;
    logic [dpc_pkg::MINN_W-1:0]   minn_reg;
    logic [dpc_pkg::GATE_W-1:0]   gate_reg;
    logic [dpc_pkg::R2_W-1:0]     r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= dpc_pkg::RADIUS_RST;
            minn_reg   <= dpc_pkg::MINN_RST;
            gate_reg   <= dpc_pkg::GATE_RST;
            r2_reg     <= dpc_pkg::R2_W'(dpc_pkg::RADIUS_RST) * dpc_pkg::R2_W'(dpc_pkg::RADIUS_RST);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    dpc_pkg::REG_RADIUS: radius_reg <= cfg_wdata[dpc_pkg::RADIUS_W-1:0];
                    dpc_pkg::REG_MINN:   minn_reg   <= cfg_wdata[dpc_pkg::MINN_W-1:0];
                    dpc_pkg::REG_GATE:   gate_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r2_reg <= dpc_pkg::R2_W'(radius_reg) * dpc_pkg::R2_W'(radius_reg);
        end
    end

    logic          accept, store_free, fifo_empty;
    logic          st_we, job_push, job_valid, job_ready;
    logic [IW-1:0] st_addr;
    logic [PW-1:0] st_data;
    dpc_pkg::job_t push_job, job;
    logic [dpc_pkg::LABEL_W-1:0] label_bits;

    // The front end may only load while the point store is not in use by the engine.
    assign s_ready = store_free && fifo_empty;
    assign accept  = s_valid && s_ready;

    dpc_front #(.POINTS(POINTS), .COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .pos_x(s_pos_x), .pos_y(s_pos_y), .pos_z(s_pos_z), .end_of_frame(s_end_of_frame),
        .height_gate(gate_reg),
        .st_we(st_we), .st_addr(st_addr), .st_data(st_data),
        .job_push(job_push), .job(push_job)
    );

    dpc_job_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(job_push), .push_job(push_job), .pop(job_ready),
        .job_valid(job_valid), .job(job), .empty(fifo_empty)
    );

    dpc_back #(.POINTS(POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .st_we(st_we), .st_addr(st_addr), .st_data(st_data),
        .job_valid(job_valid), .job(job), .job_ready(job_ready), .store_free(store_free),
        .r2(r2_reg), .min_neighbours(minn_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_kept_index(m_kept_index),
        .m_cluster_label(label_bits), .m_last_label(m_last_label), .m_overflow(m_overflow)
    );

    assign m_cluster_label = $signed(label_bits);
endmodule
`default_nettype wire

/* rtl/core/dpc_front.sv */
// Front end: accepts point requests, applies the height gate and fills the point store.
`default_nettype none
module dpc_front #(
    parameter int POINTS      = dpc_pkg::POINTS_DEF,
    parameter int COORD_WIDTH = dpc_pkg::COORD_W_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               accept,
    input  wire logic signed [COORD_WIDTH-1:0] pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] pos_z,
    input  wire                               end_of_frame,
    input  wire logic signed [dpc_pkg::GATE_W-1:0] height_gate,
    output logic                              st_we,
    output logic [$clog2(POINTS)-1:0]         st_addr,
    output logic [3*COORD_WIDTH-1:0]          st_data,
    output logic                              job_push,
    output dpc_pkg::job_t                     job
);
    localparam int IW = $clog2(POINTS);
    localparam int GW = (COORD_WIDTH > dpc_pkg::GATE_W) ? COORD_WIDTH : dpc_pkg::GATE_W;

    logic [dpc_pkg::CNT_W-1:0] count_reg, count_next, count_after;
    logic                      ovf_reg, ovf_next, ovf_after;
    logic signed [GW-1:0]      z_ext, gate_ext;
    logic                      pass, room;

    assign z_ext    = GW'(pos_z);
    assign gate_ext = GW'(height_gate);
    assign pass     = (z_ext <= gate_ext);
    assign room     = (count_reg < dpc_pkg::CNT_W'(POINTS));

    always_comb begin
        st_we       = accept && pass && room;
        st_addr     = count_reg[IW-1:0];
        st_data     = {pos_z, pos_y, pos_x};
        count_after = st_we ? count_reg + dpc_pkg::CNT_W'(1) : count_reg;
        ovf_after   = ovf_reg | (accept && pass && !room);
        job_push    = accept && end_of_frame && (count_after != '0);
        job.count   = count_after;
        job.overflow = ovf_after;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (accept) begin
            count_next = end_of_frame ? '0 : count_after;
            ovf_next   = end_of_frame ? 1'b0 : ovf_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/dpc_job_fifo.sv */
// Two-entry queue of frame jobs between the front end and the clustering engine.
`default_nettype none
module dpc_job_fifo (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire dpc_pkg::job_t push_job,
    input  wire                pop,
    output logic               job_valid,
    output dpc_pkg::job_t      job,
    output logic               empty
);
    dpc_pkg::job_t slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg;

    assign job_valid = (fill_reg != 2'd0);
    assign empty     = (fill_reg == 2'd0);
    assign job       = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && fill_reg != 2'd2) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push && fill_reg != 2'd2) begin
                wr_reg <= ~wr_reg;
            end
            if (pop && job_valid) begin
                rd_reg <= ~rd_reg;
            end
            fill_reg <= fill_reg + 2'((push && fill_reg != 2'd2) ? 1 : 0)
                                 - 2'((pop && job_valid) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/dpc_dist.sv */
// Pipelined squared-distance test of one point pair against the squared radius.
`default_nettype none
module dpc_dist #(
    parameter int POINTS      = dpc_pkg::POINTS_DEF,
    parameter int COORD_WIDTH = dpc_pkg::COORD_W_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    input  wire [$clog2(POINTS)-1:0]     in_idx,
    input  wire [3*COORD_WIDTH-1:0]      pt_a,
    input  wire [3*COORD_WIDTH-1:0]      pt_b,
    input  wire [dpc_pkg::R2_W-1:0]      r2,
    output logic                         busy,
    output logic                         out_valid,
    output logic [$clog2(POINTS)-1:0]    out_idx,
    output logic                         out_near
);
    localparam int IW   = $clog2(POINTS);
    localparam int SQW  = 2 * COORD_WIDTH;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > dpc_pkg::R2_W) ? SUMW : dpc_pkg::R2_W;

    logic [COORD_WIDTH-1:0] ad_reg [3];
    logic [COORD_WIDTH-1:0] ad_next [3];
    logic [SQW-1:0]         sq_reg [3];
    logic                   s1v_reg, s2v_reg;
    logic [IW-1:0]          idx1_reg, idx2_reg;
    logic [SUMW-1:0]        sum;

    always_comb begin
        logic signed [COORD_WIDTH:0] d;
        for (int k = 0; k < 3; k++) begin
            d = (COORD_WIDTH+1)'($signed(pt_a[k*COORD_WIDTH +: COORD_WIDTH]))
              - (COORD_WIDTH+1)'($signed(pt_b[k*COORD_WIDTH +: COORD_WIDTH]));
            ad_next[k] = d[COORD_WIDTH] ? COORD_WIDTH'(-d) : COORD_WIDTH'(d);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= SQW'(ad_reg[k]) * SQW'(ad_reg[k]);
        end
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
        end else begin
            s1v_reg <= in_valid;
            s2v_reg <= s1v_reg;
        end
    end

    assign sum       = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
    assign out_near  = (CMPW'(sum) <= CMPW'(r2));
    assign out_valid = s2v_reg;
    assign out_idx   = idx2_reg;
    assign busy      = s1v_reg;
endmodule
`default_nettype wire

/* rtl/core/dpc_back.sv */
// Back end: DBSCAN engine over the point store, frontier queue and label emission.
`default_nettype none
module dpc_back #(
    parameter int POINTS      = dpc_pkg::POINTS_DEF,
    parameter int COORD_WIDTH = dpc_pkg::COORD_W_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              st_we,
    input  wire [$clog2(POINTS)-1:0]         st_addr,
    input  wire [3*COORD_WIDTH-1:0]          st_data,
    input  wire                              job_valid,
    input  wire dpc_pkg::job_t               job,
    output logic                             job_ready,
    output logic                             store_free,
    input  wire [dpc_pkg::R2_W-1:0]          r2,
    input  wire [dpc_pkg::MINN_W-1:0]        min_neighbours,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [dpc_pkg::KEPT_W-1:0]       m_kept_index,
    output logic [dpc_pkg::LABEL_W-1:0]      m_cluster_label,
    output logic                             m_last_label,
    output logic                             m_overflow
);
    localparam int IW = $clog2(POINTS);
    localparam int PW = 3 * COORD_WIDTH;
    localparam int CW = dpc_pkg::CNT_W;
    localparam int LW = dpc_pkg::LABEL_W;

    dpc_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next, i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] count_reg, count_next, head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] e_reg, e_next;
    logic          ovf_reg, ovf_next, inner_reg, inner_next;
    logic [IW-1:0] p_reg, p_next, idx0_reg, idx0_next;
    logic          v0_reg, v0_next;
    logic [LW-1:0] lab_reg, lab_next, ncl_reg, ncl_next;
    logic [POINTS-1:0] visited_reg, visited_next, queued_reg, queued_next;
    logic [POINTS-1:0] labelled_reg, labelled_next, near_reg, near_next;
    logic [PW-1:0] p_pt_reg, p_pt_next;
    logic          mv_reg, mv_next;
    logic [dpc_pkg::KEPT_W-1:0] mk_reg, mk_next;
    logic [LW-1:0] ml_reg, ml_next;
    logic          mlast_reg, mlast_next, movf_reg, movf_next;

    logic [PW-1:0] store_mem [POINTS];
    logic [PW-1:0] pt_rd_reg;
    logic [LW-1:0] lab_mem [POINTS];
    logic [LW-1:0] lab_rd_reg;
    logic          lbd_rd_reg;
    logic [IW-1:0] q_mem [POINTS];
    logic [IW-1:0] q_rd_reg;

    logic          lab_we, q_we;
    logic [IW-1:0] lab_waddr, st_raddr;
    logic [LW-1:0] lab_wdata;

    logic          dist_busy, dist_valid, dist_near;
    logic [IW-1:0] dist_idx;
    logic          core, scan_done;
    logic [IW-1:0] i_idx, j_idx;

    assign i_idx     = i_reg[IW-1:0];
    assign j_idx     = j_reg[IW-1:0];
    assign core      = (count_reg >= CW'(min_neighbours));
    assign scan_done = (j_reg >= cnt_reg) && !v0_reg && !dist_busy;
    assign st_raddr  = (state_reg == dpc_pkg::B_PREAD) ? p_reg : j_idx;

    dpc_dist #(.POINTS(POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dist (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v0_reg), .in_idx(idx0_reg),
        .pt_a(p_pt_reg), .pt_b(pt_rd_reg), .r2(r2),
        .busy(dist_busy), .out_valid(dist_valid), .out_idx(dist_idx), .out_near(dist_near)
    );

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_addr] <= st_data;
        end
        pt_rd_reg <= store_mem[st_raddr];
        if (lab_we) begin
            lab_mem[lab_waddr] <= lab_wdata;
        end
        lab_rd_reg <= lab_mem[e_reg[IW-1:0]];
        lbd_rd_reg <= labelled_reg[e_reg[IW-1:0]];
        if (q_we) begin
            q_mem[tail_reg[IW-1:0]] <= j_idx;
        end
        q_rd_reg <= q_mem[head_reg[IW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dpc_pkg::B_IDLE:   if (job_valid) state_next = dpc_pkg::B_OUTER;
            dpc_pkg::B_OUTER: begin
                if (i_reg == cnt_reg) begin
                    state_next = dpc_pkg::B_ERD;
                end else if (!visited_reg[i_idx]) begin
                    state_next = dpc_pkg::B_PREAD;
                end
            end
            dpc_pkg::B_PREAD:  state_next = dpc_pkg::B_PLATCH;
            dpc_pkg::B_PLATCH: state_next = dpc_pkg::B_SCAN;
            dpc_pkg::B_SCAN:   if (scan_done) state_next = dpc_pkg::B_DECIDE;
            dpc_pkg::B_DECIDE: begin
                if (core) begin
                    state_next = dpc_pkg::B_PUSH;
                end else begin
                    state_next = inner_reg ? dpc_pkg::B_LABEL : dpc_pkg::B_OUTER;
                end
            end
            dpc_pkg::B_PUSH: begin
                if (j_reg >= cnt_reg) begin
                    state_next = inner_reg ? dpc_pkg::B_LABEL : dpc_pkg::B_QHEAD;
                end
            end
            dpc_pkg::B_LABEL:  state_next = dpc_pkg::B_QHEAD;
            dpc_pkg::B_QHEAD: begin
                state_next = (head_reg == tail_reg) ? dpc_pkg::B_OUTER : dpc_pkg::B_QWAIT;
            end
            dpc_pkg::B_QWAIT: begin
                state_next = visited_reg[q_rd_reg] ? dpc_pkg::B_LABEL : dpc_pkg::B_PREAD;
            end
            dpc_pkg::B_ERD:    state_next = dpc_pkg::B_EOUT;
            dpc_pkg::B_EOUT:   state_next = dpc_pkg::B_EWAIT;
            dpc_pkg::B_EWAIT: begin
                if (m_ready) begin
                    state_next = (e_reg + CW'(1) == cnt_reg) ? dpc_pkg::B_IDLE : dpc_pkg::B_ERD;
                end
            end
            default:           state_next = dpc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;   i_next = i_reg;         j_next = j_reg;
        count_next = count_reg; head_next = head_reg; tail_next = tail_reg;
        e_next = e_reg;       ovf_next = ovf_reg;     inner_next = inner_reg;
        p_next = p_reg;       idx0_next = idx0_reg;   v0_next = 1'b0;
        lab_next = lab_reg;   ncl_next = ncl_reg;
        visited_next = visited_reg; queued_next = queued_reg;
        labelled_next = labelled_reg; near_next = near_reg;
        p_pt_next = p_pt_reg;
        mv_next = mv_reg; mk_next = mk_reg; ml_next = ml_reg;
        mlast_next = mlast_reg; movf_next = movf_reg;
        lab_we = 1'b0; lab_waddr = p_reg; lab_wdata = lab_reg; q_we = 1'b0;
        unique case (state_reg)
            dpc_pkg::B_IDLE: begin
                if (job_valid) begin
                    cnt_next      = job.count;
                    ovf_next      = job.overflow;
                    visited_next  = '0;
                    labelled_next = '0;
                    ncl_next      = '0;
                    i_next        = '0;
                end
            end
            dpc_pkg::B_OUTER: begin
                if (i_reg == cnt_reg) begin
                    e_next = '0;
                end else if (visited_reg[i_idx]) begin
                    i_next = i_reg + CW'(1);
                end else begin
                    visited_next[i_idx] = 1'b1;
                    p_next     = i_idx;
                    inner_next = 1'b0;
                end
            end
            dpc_pkg::B_PREAD: begin
            end
            dpc_pkg::B_PLATCH: begin
                p_pt_next  = pt_rd_reg;
                j_next     = '0;
                count_next = '0;
            end
            dpc_pkg::B_SCAN: begin
                if (j_reg < cnt_reg) begin
                    v0_next   = 1'b1;
                    idx0_next = j_idx;
                    j_next    = j_reg + CW'(1);
                end
                if (dist_valid) begin
                    near_next[dist_idx] = dist_near;
                    count_next = count_reg + CW'(dist_near);
                end
            end
            dpc_pkg::B_DECIDE: begin
                if (core) begin
                    j_next = '0;
                end
                if (!inner_reg) begin
                    if (core) begin
                        lab_we    = 1'b1;
                        lab_wdata = ncl_reg;
                        labelled_next[p_reg] = 1'b1;
                        lab_next    = ncl_reg;
                        queued_next = '0;
                        head_next   = '0;
                        tail_next   = '0;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            dpc_pkg::B_PUSH: begin
                if (j_reg < cnt_reg) begin
                    if (near_reg[j_idx] && !queued_reg[j_idx]) begin
                        q_we = 1'b1;
                        tail_next = tail_reg + CW'(1);
                        queued_next[j_idx] = 1'b1;
                    end
                    j_next = j_reg + CW'(1);
                end
            end
            dpc_pkg::B_LABEL: begin
                if (!labelled_reg[p_reg]) begin
                    lab_we = 1'b1;
                    labelled_next[p_reg] = 1'b1;
                end
            end
            dpc_pkg::B_QHEAD: begin
                if (head_reg == tail_reg) begin
                    ncl_next = ncl_reg + LW'(1);
                    i_next   = i_reg + CW'(1);
                end else begin
                    head_next = head_reg + CW'(1);
                end
            end
            dpc_pkg::B_QWAIT: begin
                p_next = q_rd_reg;
                if (!visited_reg[q_rd_reg]) begin
                    visited_next[q_rd_reg] = 1'b1;
                    inner_next = 1'b1;
                end
            end
            dpc_pkg::B_ERD: begin
            end
            dpc_pkg::B_EOUT: begin
                mv_next    = 1'b1;
                mk_next    = dpc_pkg::KEPT_W'(e_reg);
                ml_next    = lbd_rd_reg ? lab_rd_reg : dpc_pkg::LABEL_NOISE;
                mlast_next = (e_reg + CW'(1) == cnt_reg);
                movf_next  = ovf_reg;
            end
            dpc_pkg::B_EWAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    e_next  = e_reg + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;   i_reg <= i_next;       j_reg <= j_next;
        count_reg <= count_next; head_reg <= head_next; tail_reg <= tail_next;
        e_reg <= e_next;       ovf_reg <= ovf_next;   inner_reg <= inner_next;
        p_reg <= p_next;       idx0_reg <= idx0_next;
        lab_reg <= lab_next;   ncl_reg <= ncl_next;
        near_reg <= near_next; p_pt_reg <= p_pt_next;
        mk_reg <= mk_next; ml_reg <= ml_next; mlast_reg <= mlast_next; movf_reg <= movf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dpc_pkg::B_IDLE;
            v0_reg       <= 1'b0;
            mv_reg       <= 1'b0;
            visited_reg  <= '0;
            queued_reg   <= '0;
            labelled_reg <= '0;
        end else begin
            state_reg    <= state_next;
            v0_reg       <= v0_next;
            mv_reg       <= mv_next;
            visited_reg  <= visited_next;
            queued_reg   <= queued_next;
            labelled_reg <= labelled_next;
        end
    end

    assign job_ready  = (state_reg == dpc_pkg::B_IDLE);
    assign store_free = (state_reg == dpc_pkg::B_IDLE) || (state_reg == dpc_pkg::B_ERD)
                     || (state_reg == dpc_pkg::B_EOUT) || (state_reg == dpc_pkg::B_EWAIT);
    assign m_valid         = mv_reg;
    assign m_kept_index    = mk_reg;
    assign m_cluster_label = ml_reg;
    assign m_last_label    = mlast_reg;
    assign m_overflow      = movf_reg;

    a_head_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpc_pkg::B_QHEAD) |-> (head_reg <= tail_reg))
        else $error("frontier head passed its tail");
    a_tail_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpc_pkg::B_PUSH) |-> (tail_reg <= cnt_reg))
        else $error("frontier queue holds more entries than stored points");
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpc_pkg::B_IDLE && job_valid) |=> (visited_reg == '0 && labelled_reg == '0))
        else $error("frame marks not cleared at job start");
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        v0_reg |-> (CW'(idx0_reg) < cnt_reg))
        else $error("distance scan issued beyond the stored points");
endmodule
`default_nettype wire
